// File: sv/lz77sd_pkg.sv
// ----------------------------------------------------------------------------
// lz77sd_pkg
// Shared types and constants for the LZ77 stream decompressor.
// ----------------------------------------------------------------------------
package lz77sd_pkg;

    localparam int HISTORY_DEPTH = 4096;
    localparam int RING_AW       = $clog2(HISTORY_DEPTH);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 2);

    localparam int SIZE_W = 24;   // decompressed size field
    localparam int LEN_W  = 5;    // run length, 3..18

    localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FLAG,
        PH_UNIT,
        PH_REFLO,
        PH_COPY,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

endpackage

// File: sv/lz77sd_ring_ram.sv
// ----------------------------------------------------------------------------
// lz77sd_ring_ram
// Simple dual-port RAM: one write port, one read port, registered read
// data (read-first on address collision).
// ----------------------------------------------------------------------------
module lz77sd_ring_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/lz77sd_out_fifo.sv
// ----------------------------------------------------------------------------
// lz77sd_out_fifo
// Small output FIFO; decouples the decoder from a stalling receiver.
// ----------------------------------------------------------------------------
module lz77sd_out_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  lz77sd_pkg::out_item_t      push_data,
    output logic [lz77sd_pkg::FIFO_CW-1:0] count,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lz77sd_pkg::out_item_t      m_data
);
    import lz77sd_pkg::*;

    out_item_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign count   = count_reg;
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/lz77_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lz77_stream_decompressor
// LZSS decoder with a 4096-byte history ring, one compressed byte in per
// transaction, one decompressed byte out per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: compressed bytes; s_data.start_stream marks header byte 0
//   and abandons any stream in progress. A 4-byte header (size in bytes
//   1..3, little endian) is followed by flag bytes, MSB first, each
//   covering eight units (literal byte or two-byte back-reference).
//   m_ channel: decompressed bytes. run_last flags the last byte caused by
//   one input transaction, stream_end the final byte of the stream.
//   Bytes outside a stream (idle, or after the size is reached) are taken
//   and dropped.
// Timing:
//   Literal: the byte is pushed into the output FIFO as it is accepted.
//   Back-reference low byte: starts a run of length bytes (length 3..18,
//   fewer when the run is cut at the size), one copied byte per cycle while
//   the output FIFO has room, bounded by the ring RAM read port; each copied
//   byte passes the ring RAM read register before entering the output FIFO.
// Reset: aresetn (synchronous) returns the parser to idle, empties the
//   output FIFO and zeroes the ring pointer; ring contents are not cleared.
// Stall: a 4-entry output FIFO absorbs m_ready low; copying pauses and
//   s_ready drops when it fills. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lz77_stream_decompressor (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lz77sd_pkg::in_item_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lz77sd_pkg::out_item_t  m_data
);
    import lz77sd_pkg::*;

    // parser state
    phase_t               phase_reg, phase_next;
    logic [1:0]           hdr_idx_reg, hdr_idx_next;
    logic [SIZE_W-1:0]    remain_reg, remain_next;
    logic [7:0]           flags_reg, flags_next;
    logic [2:0]           unit_reg, unit_next;
    logic [7:0]           ref_hi_reg, ref_hi_next;

    // ring pointers and copy run
    logic [RING_AW-1:0]   wp_reg, wp_next;
    logic [RING_AW-1:0]   src_reg, src_next;
    logic [LEN_W-1:0]     len_reg, len_next;

    // read data stage (one byte in flight from the ring)
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 pend_end_reg, pend_end_next;
    logic                 fwd_reg, fwd_next;
    logic [7:0]           fwd_data_reg, fwd_data_next;

    logic                 accept;
    logic                 issue;
    logic                 lit_emit;
    logic                 ring_we;
    logic [7:0]           ring_wdata;
    logic [7:0]           ring_rdata;
    logic [7:0]           copy_byte;
    logic                 push;
    out_item_t            push_data;
    logic [FIFO_CW-1:0]   fifo_count;

    lz77sd_ring_ram #(
        .DEPTH  (HISTORY_DEPTH),
        .DATA_W (8)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (wp_reg),
        .wdata (ring_wdata),
        .re    (issue),
        .raddr (src_reg),
        .rdata (ring_rdata)
    );

    lz77sd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .count     (fifo_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Input is taken only with the copy engine drained and FIFO room for a
    // literal.
    assign s_ready = (phase_reg != PH_COPY) && !pend_valid_reg
                     && (fifo_count < FIFO_CW'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    // Issue a ring read only if the FIFO can take this byte next cycle on
    // top of the one landing now.
    assign issue = (phase_reg == PH_COPY)
                   && ((fifo_count + FIFO_CW'(pend_valid_reg)) < FIFO_CW'(FIFO_DEPTH));

    // dist == 1 reads the entry written in the same cycle: bypass it
    assign copy_byte  = fwd_reg ? fwd_data_reg : ring_rdata;
    assign ring_we    = lit_emit || pend_valid_reg;
    assign ring_wdata = lit_emit ? s_data.in_byte : copy_byte;
    assign push       = ring_we;

    always_comb begin
        phase_t            ph;
        logic [1:0]        hidx;
        logic [SIZE_W-1:0] rem;
        logic [SIZE_W-1:0] rem_dec;
        logic [7:0]        flg;
        logic [2:0]        unit;
        logic [2:0]        unit_inc;
        logic [7:0]        rhi;
        logic              last;

        // start_stream resets the parse before the byte is decoded
        if (accept && s_data.start_stream) begin
            ph   = PH_HEADER;
            hidx = 2'd0;
            rem  = '0;
            flg  = 8'd0;
            unit = 3'd0;
            rhi  = 8'd0;
        end else begin
            ph   = phase_reg;
            hidx = hdr_idx_reg;
            rem  = remain_reg;
            flg  = flags_reg;
            unit = unit_reg;
            rhi  = ref_hi_reg;
        end
        rem_dec  = rem - 1'b1;
        unit_inc = unit + 1'b1;
        last     = 1'b0;

        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        remain_next     = remain_reg;
        flags_next      = flags_reg;
        unit_next       = unit_reg;
        ref_hi_next     = ref_hi_reg;
        src_next        = src_reg;
        len_next        = len_reg;
        lit_emit        = 1'b0;
        pend_valid_next = issue;
        pend_last_next  = pend_last_reg;
        pend_end_next   = pend_end_reg;

        if (accept) begin
            phase_next   = ph;
            hdr_idx_next = hidx;
            remain_next  = rem;
            flags_next   = flg;
            unit_next    = unit;
            ref_hi_next  = rhi;
            case (ph)
                PH_HEADER: begin
                    case (hidx)
                        2'd1:    remain_next = rem | {16'd0, s_data.in_byte};
                        2'd2:    remain_next = rem | {8'd0, s_data.in_byte, 8'd0};
                        2'd3:    remain_next = rem | {s_data.in_byte, 16'd0};
                        default: remain_next = rem;
                    endcase
                    hdr_idx_next = hidx + 1'b1;
                    if (hidx == 2'd3) begin
                        phase_next = (remain_next == '0) ? PH_DONE : PH_FLAG;
                    end
                end
                PH_FLAG: begin
                    flags_next = s_data.in_byte;
                    unit_next  = 3'd0;
                    phase_next = PH_UNIT;
                end
                PH_UNIT: begin
                    if (!flg[3'd7 - unit]) begin
                        lit_emit    = 1'b1;
                        remain_next = rem_dec;
                        unit_next   = unit_inc;
                        if (rem_dec == '0) begin
                            phase_next = PH_DONE;
                        end else if (unit_inc == 3'd0) begin
                            phase_next = PH_FLAG;
                        end else begin
                            phase_next = PH_UNIT;
                        end
                    end else begin
                        ref_hi_next = s_data.in_byte;
                        phase_next  = PH_REFLO;
                    end
                end
                PH_REFLO: begin
                    // src = wp - (offset + 1)
                    len_next   = LEN_W'(rhi[7:4]) + LEN_BIAS;
                    src_next   = wp_reg + ~RING_AW'({rhi[3:0], s_data.in_byte});
                    phase_next = PH_COPY;
                end
                default: begin
                end
            endcase
        end

        if (issue) begin
            last           = (len_reg == LEN_W'(1)) || (remain_reg == SIZE_W'(1));
            remain_next    = remain_reg - 1'b1;
            len_next       = len_reg - 1'b1;
            src_next       = src_reg + 1'b1;
            pend_last_next = last;
            pend_end_next  = (remain_reg == SIZE_W'(1));
            if (last) begin
                unit_next = unit_reg + 1'b1;
                if (remain_reg == SIZE_W'(1)) begin
                    phase_next = PH_DONE;
                end else if (unit_reg == 3'd7) begin
                    phase_next = PH_FLAG;
                end else begin
                    phase_next = PH_UNIT;
                end
            end
        end
    end

    always_comb begin
        wp_next       = ring_we ? wp_reg + 1'b1 : wp_reg;
        fwd_next      = issue && ring_we && (src_reg == wp_reg);
        fwd_data_next = ring_wdata;
        if (lit_emit) begin
            push_data.out_byte   = s_data.in_byte;
            push_data.run_last   = 1'b1;
            push_data.stream_end = (remain_next == '0);
        end else begin
            push_data.out_byte   = copy_byte;
            push_data.run_last   = pend_last_reg;
            push_data.stream_end = pend_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hdr_idx_reg    <= 2'd0;
            remain_reg     <= '0;
            flags_reg      <= 8'd0;
            unit_reg       <= 3'd0;
            ref_hi_reg     <= 8'd0;
            wp_reg         <= '0;
            src_reg        <= '0;
            len_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_end_reg   <= 1'b0;
            fwd_reg        <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            remain_reg     <= remain_next;
            flags_reg      <= flags_next;
            unit_reg       <= unit_next;
            ref_hi_reg     <= ref_hi_next;
            wp_reg         <= wp_next;
            src_reg        <= src_next;
            len_reg        <= len_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            pend_end_reg   <= pend_end_next;
            fwd_reg        <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= fwd_data_next;
    end

endmodule
